/* rtl/core/utf8_to_unicode_escape_top_defines.svh */
// Assertion macros for the UTF-8 escape converter.
`ifndef UTF8_TO_UNICODE_ESCAPE_TOP_DEFINES_SVH
`define UTF8_TO_UNICODE_ESCAPE_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define U8ESC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("u8esc check failed");

// Check a property on every clock edge, reset included.
`define U8ESC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("u8esc check failed");

`endif

/* rtl/core/u8esc_pkg.sv */
// Shared types, ASCII codes and hex helpers for the UTF-8 escape converter.
package u8esc_pkg;

  localparam int unsigned BufLen = 12;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowerU = 8'h75;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] CodeLf   = 8'h0A;
  localparam logic [7:0] CodeCr   = 8'h0D;
  localparam logic [7:0] CodeTab  = 8'h09;
  localparam logic [7:0] CodeDel  = 8'h7F;

  localparam logic [20:0] SuppBase = 21'h10000;
  localparam logic [15:0] HiSurr   = 16'hD800;
  localparam logic [15:0] LoSurr   = 16'hDC00;

  typedef logic [BufLen-1:0][7:0] obuf_t;
  typedef logic [5:0][7:0] uesc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'h0, nib};
    end else begin
      res = 8'h37 + {4'h0, nib};
    end
    return res;
  endfunction

  function automatic uesc_t u_escape(input logic [15:0] v);
    uesc_t res;
    res[0] = ChBslash;
    res[1] = ChLowerU;
    res[2] = hex_char(v[15:12]);
    res[3] = hex_char(v[11:8]);
    res[4] = hex_char(v[7:4]);
    res[5] = hex_char(v[3:0]);
    return res;
  endfunction

endpackage

/* rtl/core/utf8_to_unicode_escape_top.sv */
// UTF-8 to escaped ASCII converter: one input byte in, zero to twelve bytes out.
//
//   channel | signals                          | role
//   in      | in_valid_i in_ready_o in_byte_i  | one UTF-8 byte per beat, zero ends text
//   out     | out_valid_o out_ready_i          | one output byte per beat,
//           | out_byte_o run_last_o            | run_last_o marks an item's final byte
//
// Each accepted byte is decoded in its accept cycle and its output bytes land in a
// 12-byte shift buffer; the buffer drains one byte per cycle.
// A new byte is taken while the last buffered byte leaves, so items run back to back.
// Out stalls hold the buffer; reset clears the sequence state and empties the buffer.
`include "utf8_to_unicode_escape_top_defines.svh"

module utf8_to_unicode_escape_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  logic [7:0]  lead_q, lead_d;
  logic [2:0]  exp_q, exp_d;
  logic [1:0]  bg_q, bg_d;
  logic [20:0] partial_q, partial_d;
  logic [1:0][7:0] cont_q, cont_d;

  u8esc_pkg::obuf_t obuf_q, obuf_d, fill;
  logic [3:0] cnt_q, cnt_d;

  logic in_acc, out_acc;
  logic fresh;
  logic [20:0] cp, off;
  logic [15:0] hi_w, lo_w;
  logic [3:0][7:0]  raw;
  logic [15:0][7:0] tail;
  logic [1:0] raw_n;
  logic [3:0] tail_n, tot_n, tidx;

  assign in_ready_o  = (cnt_q == 4'd0) || ((cnt_q == 4'd1) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 4'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign out_byte_o  = obuf_q[0];
  assign run_last_o  = (cnt_q == 4'd1);

  always_comb begin
    lead_d    = lead_q;
    exp_d     = exp_q;
    bg_d      = bg_q;
    partial_d = partial_q;
    cont_d    = cont_q;
    raw       = {8'h00, cont_q[1], cont_q[0], lead_q};
    raw_n     = 2'd0;
    tail      = '0;
    tail_n    = 4'd0;
    fresh     = 1'b1;
    cp        = {partial_q[14:0], in_byte_i[5:0]};
    off       = cp - u8esc_pkg::SuppBase;
    hi_w      = u8esc_pkg::HiSurr + {5'b0, off[20:10]};
    lo_w      = u8esc_pkg::LoSurr + {6'b0, off[9:0]};

    if (exp_q != 3'd0) begin
      if (in_byte_i[7:6] == 2'b10) begin
        fresh     = 1'b0;
        partial_d = cp;
        if (({2'b00, bg_q} + 4'd2) >= {1'b0, exp_q}) begin
          lead_d    = '0;
          exp_d     = '0;
          bg_d      = '0;
          partial_d = '0;
          if (|cp[20:16]) begin
            tail[5:0]  = u8esc_pkg::u_escape(hi_w);
            tail[11:6] = u8esc_pkg::u_escape(lo_w);
            tail_n     = 4'd12;
          end else begin
            tail[5:0] = u8esc_pkg::u_escape(cp[15:0]);
            tail_n    = 4'd6;
          end
        end else begin
          cont_d[bg_q[0]] = in_byte_i;
          bg_d            = bg_q + 2'd1;
        end
      end else begin
        raw_n     = bg_q + 2'd1;
        lead_d    = '0;
        exp_d     = '0;
        bg_d      = '0;
        partial_d = '0;
      end
    end

    if (fresh && (in_byte_i != 8'h00)) begin
      if (in_byte_i[7:5] == 3'b110) begin
        lead_d    = in_byte_i;
        exp_d     = 3'd2;
        bg_d      = '0;
        partial_d = {16'b0, in_byte_i[4:0]};
      end else if (in_byte_i[7:4] == 4'b1110) begin
        lead_d    = in_byte_i;
        exp_d     = 3'd3;
        bg_d      = '0;
        partial_d = {17'b0, in_byte_i[3:0]};
      end else if (in_byte_i[7:3] == 5'b11110) begin
        lead_d    = in_byte_i;
        exp_d     = 3'd4;
        bg_d      = '0;
        partial_d = {18'b0, in_byte_i[2:0]};
      end else if ((in_byte_i < 8'h20) || (in_byte_i == u8esc_pkg::CodeDel)) begin
        tail[0] = u8esc_pkg::ChBslash;
        tail_n  = 4'd2;
        case (in_byte_i)
          u8esc_pkg::CodeLf:  tail[1] = u8esc_pkg::ChLowerN;
          u8esc_pkg::CodeCr:  tail[1] = u8esc_pkg::ChLowerR;
          u8esc_pkg::CodeTab: tail[1] = u8esc_pkg::ChLowerT;
          default: begin
            tail[5:0] = u8esc_pkg::u_escape({8'h00, in_byte_i});
            tail_n    = 4'd6;
          end
        endcase
      end else if (in_byte_i == u8esc_pkg::ChBslash) begin
        tail[0] = u8esc_pkg::ChBslash;
        tail[1] = u8esc_pkg::ChBslash;
        tail_n  = 4'd2;
      end else begin
        tail[0] = in_byte_i;
        tail_n  = 4'd1;
      end
    end

    tot_n = {2'b00, raw_n} + tail_n;
    for (int k = 0; k < u8esc_pkg::BufLen; k++) begin
      tidx = 4'(k) - {2'b00, raw_n};
      if (4'(k) < {2'b00, raw_n}) begin
        fill[k] = raw[2'(k)];
      end else begin
        fill[k] = tail[tidx];
      end
    end
  end

  always_comb begin
    obuf_d = obuf_q;
    cnt_d  = cnt_q;
    if (out_acc) begin
      obuf_d = {8'h00, obuf_q[u8esc_pkg::BufLen-1:1]};
      cnt_d  = cnt_q - 4'd1;
    end
    if (in_acc && (tot_n != 4'd0)) begin
      obuf_d = fill;
      cnt_d  = tot_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      exp_q     <= '0;
      bg_q      <= '0;
      partial_q <= '0;
      cnt_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        lead_q    <= lead_d;
        exp_q     <= exp_d;
        bg_q      <= bg_d;
        partial_q <= partial_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
    if (in_acc) begin
      cont_q <= cont_d;
    end
  end

  `U8ESC_ASSERT(a_cnt_range, cnt_q <= 4'd12)
  `U8ESC_ASSERT(a_gather_below_len,
    (exp_q != 3'd0) |-> (({2'b00, bg_q} + 4'd2) <= {1'b0, exp_q}))
  `U8ESC_ASSERT(a_idle_seq_clear,
    (exp_q == 3'd0) |-> ((partial_q == 21'd0) && (bg_q == 2'd0) && (lead_q == 8'h00)))

endmodule
